// ----- sv/trsr_pkg.sv -----
// Shared constants and types for the triangle scan rasteriser.
// Used by every module of the block; depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none

package trsr_pkg;

    // Defaults for the top-level parameters
    localparam int MAX_SCREEN_DEF = 4096;
    localparam int COORD_BITS_DEF = 16;

    // Fixed field widths
    localparam int CFG_W     = 13;
    localparam int CFG_IDX_W = 1;
    localparam int COLOR_W   = 32;
    localparam int PIX_W     = 12;

    // Register reset values
    localparam logic [CFG_W-1:0] WIDTH_RST  = 13'd640;
    localparam logic [CFG_W-1:0] HEIGHT_RST = 13'd480;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_WIDTH  = 1'b0,
        REG_HEIGHT = 1'b1
    } t_cfg_reg;

    // Input beat opcodes
    typedef enum logic {
        OP_LOAD = 1'b0,
        OP_STEP = 1'b1
    } t_op;

    // Stage control passed down the pipeline
    typedef struct packed {
        logic valid;
        logic load;
    } t_ctl;

endpackage

`default_nettype wire

// ----- sv/triangle_scan_rasterizer_unit.sv -----
// An accepted beat passes the input register, setup and multiply, then the scan stage,
// which spends one add per edge on each pixel step and, for a step, loads the result register.
// Throughput: one beat per cycle while the receiver does not stall the result channel.
// Loads give no result beat and pass the scan stage even while the result register is full.
// Reset (synchronous, active low) empties the pipeline, stops any scan and sets the screen
// registers to 640 by 480; a step after reset gives one uncovered beat with last set.
`timescale 1ns / 1ps
`default_nettype none

module triangle_scan_rasterizer_unit #(
    parameter int MAX_SCREEN = trsr_pkg::MAX_SCREEN_DEF,
    parameter int COORD_BITS = trsr_pkg::COORD_BITS_DEF
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    // Configuration writes
    input  wire logic                              i_cfg_we,
    input  wire logic [trsr_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  wire logic [trsr_pkg::CFG_W-1:0]        i_cfg_data,
    // Input channel
    input  wire logic                              i_in_valid,
    output logic                                   o_in_ready,
    input  wire logic                              i_op,
    input  wire logic signed [COORD_BITS-1:0]      i_ax,
    input  wire logic signed [COORD_BITS-1:0]      i_ay,
    input  wire logic signed [COORD_BITS-1:0]      i_bx,
    input  wire logic signed [COORD_BITS-1:0]      i_by_coord,
    input  wire logic signed [COORD_BITS-1:0]      i_cx_coord,
    input  wire logic signed [COORD_BITS-1:0]      i_cy_coord,
    input  wire logic [trsr_pkg::COLOR_W-1:0]      i_fill_color,
    // Result channel
    output logic                                   o_out_valid,
    input  wire logic                              i_out_ready,
    output logic [trsr_pkg::PIX_W-1:0]             o_pixel_x,
    output logic [trsr_pkg::PIX_W-1:0]             o_pixel_y,
    output logic                                   o_covered,
    output logic [trsr_pkg::COLOR_W-1:0]           o_pixel_color,
    output logic                                   o_last
);

    localparam int CB = COORD_BITS;
    localparam int SB = $clog2(MAX_SCREEN) + 1;
    localparam int CW = (CB > SB + 1) ? CB : SB + 1;
    localparam int DW = CW + 1;
    localparam int PW = CB + 1 + DW;

    // Screen registers
    logic [trsr_pkg::CFG_W-1:0] r_cfg_w, r_cfg_h;

    // Input register
    logic                   r1_valid;
    trsr_pkg::t_op          r1_op;
    logic signed [CB-1:0]   r1_vx [3];
    logic signed [CB-1:0]   r1_vy [3];
    logic [trsr_pkg::COLOR_W-1:0] r1_color;
    trsr_pkg::t_ctl         ctl1;

    // Setup stage outputs
    logic                   setup_free;
    trsr_pkg::t_ctl         ctl2;
    logic signed [CB:0]     s2_a [3];
    logic signed [CB:0]     s2_b [3];
    logic signed [DW-1:0]   s2_dx [3];
    logic signed [DW-1:0]   s2_dy [3];
    logic signed [DW-1:0]   s2_ddx, s2_ddy;
    logic [SB-1:0]          s2_xmin, s2_xmax, s2_ymin, s2_ymax;
    logic [trsr_pkg::COLOR_W-1:0] s2_color;

    // Multiply stage outputs
    logic                   mul_free;
    trsr_pkg::t_ctl         ctl3;
    logic signed [CB:0]     s3_a [3];
    logic signed [CB:0]     s3_b [3];
    logic signed [PW-1:0]   s3_pex [3];
    logic signed [PW-1:0]   s3_pey [3];
    logic signed [PW-1:0]   s3_pd0, s3_pd1;
    logic [SB-1:0]          s3_xmin, s3_xmax, s3_ymin, s3_ymax;
    logic [trsr_pkg::COLOR_W-1:0] s3_color;

    logic                   scan_take;

    // Configuration register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_w <= trsr_pkg::WIDTH_RST;
            r_cfg_h <= trsr_pkg::HEIGHT_RST;
        end else if (i_cfg_we) begin
            unique case (trsr_pkg::t_cfg_reg'(i_cfg_index))
                trsr_pkg::REG_WIDTH:  r_cfg_w <= i_cfg_data;
                trsr_pkg::REG_HEIGHT: r_cfg_h <= i_cfg_data;
            endcase
        end
    end

    // Input register
    assign o_in_ready = !r1_valid || setup_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
        end else if (o_in_ready) begin
            r1_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r1_op    <= trsr_pkg::t_op'(i_op);
            r1_vx[0] <= i_ax;
            r1_vx[1] <= i_bx;
            r1_vx[2] <= i_cx_coord;
            r1_vy[0] <= i_ay;
            r1_vy[1] <= i_by_coord;
            r1_vy[2] <= i_cy_coord;
            r1_color <= i_fill_color;
        end
    end

    assign ctl1 = '{valid: r1_valid, load: (r1_op == trsr_pkg::OP_LOAD)};

    trsr_setup #(
        .MAX_SCREEN (MAX_SCREEN),
        .COORD_BITS (COORD_BITS)
    ) u_setup (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (ctl1),
        .i_vx       (r1_vx),
        .i_vy       (r1_vy),
        .i_color    (r1_color),
        .i_cfg_w    (r_cfg_w),
        .i_cfg_h    (r_cfg_h),
        .i_dn_free  (mul_free),
        .o_free     (setup_free),
        .o_ctl      (ctl2),
        .o_a        (s2_a),
        .o_b        (s2_b),
        .o_dx       (s2_dx),
        .o_dy       (s2_dy),
        .o_ddx      (s2_ddx),
        .o_ddy      (s2_ddy),
        .o_xmin     (s2_xmin),
        .o_xmax     (s2_xmax),
        .o_ymin     (s2_ymin),
        .o_ymax     (s2_ymax),
        .o_color    (s2_color)
    );

    trsr_mul #(
        .MAX_SCREEN (MAX_SCREEN),
        .COORD_BITS (COORD_BITS)
    ) u_mul (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (ctl2),
        .i_a        (s2_a),
        .i_b        (s2_b),
        .i_dx       (s2_dx),
        .i_dy       (s2_dy),
        .i_ddx      (s2_ddx),
        .i_ddy      (s2_ddy),
        .i_xmin     (s2_xmin),
        .i_xmax     (s2_xmax),
        .i_ymin     (s2_ymin),
        .i_ymax     (s2_ymax),
        .i_color    (s2_color),
        .i_dn_free  (scan_take),
        .o_free     (mul_free),
        .o_ctl      (ctl3),
        .o_a        (s3_a),
        .o_b        (s3_b),
        .o_pex      (s3_pex),
        .o_pey      (s3_pey),
        .o_pd0      (s3_pd0),
        .o_pd1      (s3_pd1),
        .o_xmin     (s3_xmin),
        .o_xmax     (s3_xmax),
        .o_ymin     (s3_ymin),
        .o_ymax     (s3_ymax),
        .o_color    (s3_color)
    );

    trsr_scan #(
        .MAX_SCREEN (MAX_SCREEN),
        .COORD_BITS (COORD_BITS)
    ) u_scan (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_ctl          (ctl3),
        .i_a            (s3_a),
        .i_b            (s3_b),
        .i_pex          (s3_pex),
        .i_pey          (s3_pey),
        .i_pd0          (s3_pd0),
        .i_pd1          (s3_pd1),
        .i_xmin         (s3_xmin),
        .i_xmax         (s3_xmax),
        .i_ymin         (s3_ymin),
        .i_ymax         (s3_ymax),
        .i_color        (s3_color),
        .i_out_ready    (i_out_ready),
        .o_take         (scan_take),
        .o_out_valid    (o_out_valid),
        .o_pixel_x      (o_pixel_x),
        .o_pixel_y      (o_pixel_y),
        .o_covered      (o_covered),
        .o_pixel_color  (o_pixel_color),
        .o_last         (o_last)
    );

endmodule

`default_nettype wire

// ----- sv/trsr_setup.sv -----
// Setup stage: edge coefficients, clamped bounding box and offsets to the box origin.
// Depends on trsr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module trsr_setup #(
    parameter int MAX_SCREEN = trsr_pkg::MAX_SCREEN_DEF,
    parameter int COORD_BITS = trsr_pkg::COORD_BITS_DEF
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire trsr_pkg::t_ctl                    i_ctl,
    input  wire logic signed [COORD_BITS-1:0]      i_vx [3],
    input  wire logic signed [COORD_BITS-1:0]      i_vy [3],
    input  wire logic [trsr_pkg::COLOR_W-1:0]      i_color,
    input  wire logic [trsr_pkg::CFG_W-1:0]        i_cfg_w,
    input  wire logic [trsr_pkg::CFG_W-1:0]        i_cfg_h,
    input  wire logic                              i_dn_free,
    output logic                                   o_free,
    output trsr_pkg::t_ctl                         o_ctl,
    output logic signed [COORD_BITS:0]             o_a [3],
    output logic signed [COORD_BITS:0]             o_b [3],
    output logic signed [((COORD_BITS > $clog2(MAX_SCREEN) + 2) ? COORD_BITS
                          : $clog2(MAX_SCREEN) + 2):0] o_dx [3],
    output logic signed [((COORD_BITS > $clog2(MAX_SCREEN) + 2) ? COORD_BITS
                          : $clog2(MAX_SCREEN) + 2):0] o_dy [3],
    output logic signed [((COORD_BITS > $clog2(MAX_SCREEN) + 2) ? COORD_BITS
                          : $clog2(MAX_SCREEN) + 2):0] o_ddx,
    output logic signed [((COORD_BITS > $clog2(MAX_SCREEN) + 2) ? COORD_BITS
                          : $clog2(MAX_SCREEN) + 2):0] o_ddy,
    output logic [$clog2(MAX_SCREEN):0]            o_xmin,
    output logic [$clog2(MAX_SCREEN):0]            o_xmax,
    output logic [$clog2(MAX_SCREEN):0]            o_ymin,
    output logic [$clog2(MAX_SCREEN):0]            o_ymax,
    output logic [trsr_pkg::COLOR_W-1:0]           o_color
);

    localparam int CB = COORD_BITS;
    localparam int SB = $clog2(MAX_SCREEN) + 1;
    localparam int CW = (CB > SB + 1) ? CB : SB + 1;
    localparam int DW = CW + 1;

    logic                   r_valid;
    logic                   r_load;
    logic signed [CB:0]     r_a [3];
    logic signed [CB:0]     r_b [3];
    logic signed [DW-1:0]   r_dx [3];
    logic signed [DW-1:0]   r_dy [3];
    logic signed [DW-1:0]   r_ddx;
    logic signed [DW-1:0]   r_ddy;
    logic [SB-1:0]          r_xmin, r_xmax, r_ymin, r_ymax;
    logic [trsr_pkg::COLOR_W-1:0] r_color;

    logic signed [CB:0]     n_a [3];
    logic signed [CB:0]     n_b [3];
    logic signed [DW-1:0]   n_dx [3];
    logic signed [DW-1:0]   n_dy [3];
    logic signed [DW-1:0]   n_ddx;
    logic signed [DW-1:0]   n_ddy;
    logic [SB-1:0]          n_xmin, n_xmax, n_ymin, n_ymax;
    logic signed [CB-1:0]   xlo, xhi, ylo, yhi;
    logic [SB-1:0]          lim_x, lim_y;
    logic                   capture;

    // Clamp a vertex coordinate to 0..lim
    function automatic logic [SB-1:0] clamp_lim(input logic signed [CB-1:0] v,
                                                input logic [SB-1:0] lim);
        logic signed [CW-1:0] v_w;
        logic signed [CW-1:0] lim_w;
        v_w   = CW'(v);
        lim_w = $signed(CW'(lim));
        if (v_w < 0) begin
            clamp_lim = '0;
        end else if (v_w > lim_w) begin
            clamp_lim = lim;
        end else begin
            clamp_lim = v_w[SB-1:0];
        end
    endfunction

    // Screen limits, capped at the largest supported frame
    assign lim_x = (32'(i_cfg_w) > MAX_SCREEN) ? SB'(MAX_SCREEN) : SB'(i_cfg_w);
    assign lim_y = (32'(i_cfg_h) > MAX_SCREEN) ? SB'(MAX_SCREEN) : SB'(i_cfg_h);

    // Vertex extents
    always_comb begin
        xlo = i_vx[0];
        xhi = i_vx[0];
        ylo = i_vy[0];
        yhi = i_vy[0];
        for (int k = 1; k < 3; k++) begin
            if (i_vx[k] < xlo) xlo = i_vx[k];
            if (i_vx[k] > xhi) xhi = i_vx[k];
            if (i_vy[k] < ylo) ylo = i_vy[k];
            if (i_vy[k] > yhi) yhi = i_vy[k];
        end
        n_xmin = clamp_lim(xlo, lim_x);
        n_xmax = clamp_lim(xhi, lim_x);
        n_ymin = clamp_lim(ylo, lim_y);
        n_ymax = clamp_lim(yhi, lim_y);
    end

    // Edge j runs from vertex U to vertex W; its value at the box origin is
    // A*(x0 - xU) + B*(y0 - yU)
    for (genvar j = 0; j < 3; j++) begin : g_edge
        localparam int U = (j + 1) % 3;
        localparam int W = (j + 2) % 3;
        assign n_a[j]  = (CB+1)'(i_vy[U]) - (CB+1)'(i_vy[W]);
        assign n_b[j]  = (CB+1)'(i_vx[W]) - (CB+1)'(i_vx[U]);
        assign n_dx[j] = DW'($signed({1'b0, n_xmin})) - DW'(i_vx[U]);
        assign n_dy[j] = DW'($signed({1'b0, n_ymin})) - DW'(i_vy[U]);
    end

    // Offsets of vertex a from vertex b, for the area term
    assign n_ddx = DW'(i_vx[0]) - DW'(i_vx[1]);
    assign n_ddy = DW'(i_vy[0]) - DW'(i_vy[1]);

    assign o_free  = !r_valid || i_dn_free;
    assign capture = o_free && i_ctl.valid;

    // Stage valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_free) begin
            r_valid <= i_ctl.valid;
        end
    end

    // Stage payload
    always_ff @(posedge i_clk) begin
        if (capture) begin
            r_load  <= i_ctl.load;
            r_a     <= n_a;
            r_b     <= n_b;
            r_dx    <= n_dx;
            r_dy    <= n_dy;
            r_ddx   <= n_ddx;
            r_ddy   <= n_ddy;
            r_xmin  <= n_xmin;
            r_xmax  <= n_xmax;
            r_ymin  <= n_ymin;
            r_ymax  <= n_ymax;
            r_color <= i_color;
        end
    end

    assign o_ctl   = '{valid: r_valid, load: r_load};
    assign o_a     = r_a;
    assign o_b     = r_b;
    assign o_dx    = r_dx;
    assign o_dy    = r_dy;
    assign o_ddx   = r_ddx;
    assign o_ddy   = r_ddy;
    assign o_xmin  = r_xmin;
    assign o_xmax  = r_xmax;
    assign o_ymin  = r_ymin;
    assign o_ymax  = r_ymax;
    assign o_color = r_color;

endmodule

`default_nettype wire

// ----- sv/trsr_mul.sv -----
// Multiply stage: edge values at the box origin and the doubled triangle area.
// Depends on trsr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module trsr_mul #(
    parameter int MAX_SCREEN = trsr_pkg::MAX_SCREEN_DEF,
    parameter int COORD_BITS = trsr_pkg::COORD_BITS_DEF
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire trsr_pkg::t_ctl                    i_ctl,
    input  wire logic signed [COORD_BITS:0]        i_a [3],
    input  wire logic signed [COORD_BITS:0]        i_b [3],
    input  wire logic signed [((COORD_BITS > $clog2(MAX_SCREEN) + 2) ? COORD_BITS
                               : $clog2(MAX_SCREEN) + 2):0] i_dx [3],
    input  wire logic signed [((COORD_BITS > $clog2(MAX_SCREEN) + 2) ? COORD_BITS
                               : $clog2(MAX_SCREEN) + 2):0] i_dy [3],
    input  wire logic signed [((COORD_BITS > $clog2(MAX_SCREEN) + 2) ? COORD_BITS
                               : $clog2(MAX_SCREEN) + 2):0] i_ddx,
    input  wire logic signed [((COORD_BITS > $clog2(MAX_SCREEN) + 2) ? COORD_BITS
                               : $clog2(MAX_SCREEN) + 2):0] i_ddy,
    input  wire logic [$clog2(MAX_SCREEN):0]       i_xmin,
    input  wire logic [$clog2(MAX_SCREEN):0]       i_xmax,
    input  wire logic [$clog2(MAX_SCREEN):0]       i_ymin,
    input  wire logic [$clog2(MAX_SCREEN):0]       i_ymax,
    input  wire logic [trsr_pkg::COLOR_W-1:0]      i_color,
    input  wire logic                              i_dn_free,
    output logic                                   o_free,
    output trsr_pkg::t_ctl                         o_ctl,
    output logic signed [COORD_BITS:0]             o_a [3],
    output logic signed [COORD_BITS:0]             o_b [3],
    output logic signed [COORD_BITS + 1 + ((COORD_BITS > $clog2(MAX_SCREEN) + 2)
                         ? COORD_BITS : $clog2(MAX_SCREEN) + 2):0] o_pex [3],
    output logic signed [COORD_BITS + 1 + ((COORD_BITS > $clog2(MAX_SCREEN) + 2)
                         ? COORD_BITS : $clog2(MAX_SCREEN) + 2):0] o_pey [3],
    output logic signed [COORD_BITS + 1 + ((COORD_BITS > $clog2(MAX_SCREEN) + 2)
                         ? COORD_BITS : $clog2(MAX_SCREEN) + 2):0] o_pd0,
    output logic signed [COORD_BITS + 1 + ((COORD_BITS > $clog2(MAX_SCREEN) + 2)
                         ? COORD_BITS : $clog2(MAX_SCREEN) + 2):0] o_pd1,
    output logic [$clog2(MAX_SCREEN):0]            o_xmin,
    output logic [$clog2(MAX_SCREEN):0]            o_xmax,
    output logic [$clog2(MAX_SCREEN):0]            o_ymin,
    output logic [$clog2(MAX_SCREEN):0]            o_ymax,
    output logic [trsr_pkg::COLOR_W-1:0]           o_color
);

    localparam int CB = COORD_BITS;
    localparam int SB = $clog2(MAX_SCREEN) + 1;
    localparam int CW = (CB > SB + 1) ? CB : SB + 1;
    localparam int DW = CW + 1;
    localparam int PW = CB + 1 + DW;

    logic                   r_valid;
    logic                   r_load;
    logic signed [CB:0]     r_a [3];
    logic signed [CB:0]     r_b [3];
    logic signed [PW-1:0]   r_pex [3];
    logic signed [PW-1:0]   r_pey [3];
    logic signed [PW-1:0]   r_pd0, r_pd1;
    logic [SB-1:0]          r_xmin, r_xmax, r_ymin, r_ymax;
    logic [trsr_pkg::COLOR_W-1:0] r_color;

    logic signed [PW-1:0]   n_pex [3];
    logic signed [PW-1:0]   n_pey [3];
    logic signed [PW-1:0]   n_pd0, n_pd1;
    logic                   capture;

    // One signed product per term, registered before the sums
    for (genvar j = 0; j < 3; j++) begin : g_prod
        assign n_pex[j] = PW'(i_a[j]) * PW'(i_dx[j]);
        assign n_pey[j] = PW'(i_b[j]) * PW'(i_dy[j]);
    end
    assign n_pd0 = PW'(i_a[0]) * PW'(i_ddx);
    assign n_pd1 = PW'(i_b[0]) * PW'(i_ddy);

    assign o_free  = !r_valid || i_dn_free;
    assign capture = o_free && i_ctl.valid;

    // Stage valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_free) begin
            r_valid <= i_ctl.valid;
        end
    end

    // Stage payload
    always_ff @(posedge i_clk) begin
        if (capture) begin
            r_load  <= i_ctl.load;
            r_a     <= i_a;
            r_b     <= i_b;
            r_pex   <= n_pex;
            r_pey   <= n_pey;
            r_pd0   <= n_pd0;
            r_pd1   <= n_pd1;
            r_xmin  <= i_xmin;
            r_xmax  <= i_xmax;
            r_ymin  <= i_ymin;
            r_ymax  <= i_ymax;
            r_color <= i_color;
        end
    end

    assign o_ctl   = '{valid: r_valid, load: r_load};
    assign o_a     = r_a;
    assign o_b     = r_b;
    assign o_pex   = r_pex;
    assign o_pey   = r_pey;
    assign o_pd0   = r_pd0;
    assign o_pd1   = r_pd1;
    assign o_xmin  = r_xmin;
    assign o_xmax  = r_xmax;
    assign o_ymin  = r_ymin;
    assign o_ymax  = r_ymax;
    assign o_color = r_color;

endmodule

`default_nettype wire

// ----- sv/trsr_scan.sv -----
// Scan stage: triangle state, incremental edge values, coverage test and result register.
// Depends on trsr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module trsr_scan #(
    parameter int MAX_SCREEN = trsr_pkg::MAX_SCREEN_DEF,
    parameter int COORD_BITS = trsr_pkg::COORD_BITS_DEF
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire trsr_pkg::t_ctl                    i_ctl,
    input  wire logic signed [COORD_BITS:0]        i_a [3],
    input  wire logic signed [COORD_BITS:0]        i_b [3],
    input  wire logic signed [COORD_BITS + 1 + ((COORD_BITS > $clog2(MAX_SCREEN) + 2)
                              ? COORD_BITS : $clog2(MAX_SCREEN) + 2):0] i_pex [3],
    input  wire logic signed [COORD_BITS + 1 + ((COORD_BITS > $clog2(MAX_SCREEN) + 2)
                              ? COORD_BITS : $clog2(MAX_SCREEN) + 2):0] i_pey [3],
    input  wire logic signed [COORD_BITS + 1 + ((COORD_BITS > $clog2(MAX_SCREEN) + 2)
                              ? COORD_BITS : $clog2(MAX_SCREEN) + 2):0] i_pd0,
    input  wire logic signed [COORD_BITS + 1 + ((COORD_BITS > $clog2(MAX_SCREEN) + 2)
                              ? COORD_BITS : $clog2(MAX_SCREEN) + 2):0] i_pd1,
    input  wire logic [$clog2(MAX_SCREEN):0]       i_xmin,
    input  wire logic [$clog2(MAX_SCREEN):0]       i_xmax,
    input  wire logic [$clog2(MAX_SCREEN):0]       i_ymin,
    input  wire logic [$clog2(MAX_SCREEN):0]       i_ymax,
    input  wire logic [trsr_pkg::COLOR_W-1:0]      i_color,
    input  wire logic                              i_out_ready,
    output logic                                   o_take,
    output logic                                   o_out_valid,
    output logic [trsr_pkg::PIX_W-1:0]             o_pixel_x,
    output logic [trsr_pkg::PIX_W-1:0]             o_pixel_y,
    output logic                                   o_covered,
    output logic [trsr_pkg::COLOR_W-1:0]           o_pixel_color,
    output logic                                   o_last
);

    localparam int CB = COORD_BITS;
    localparam int SB = $clog2(MAX_SCREEN) + 1;
    localparam int CW = (CB > SB + 1) ? CB : SB + 1;
    localparam int DW = CW + 1;
    localparam int PW = CB + 1 + DW;
    localparam int EW = PW + 1;

    // Triangle state
    logic                   r_active;
    logic signed [CB:0]     r_a [3];
    logic signed [CB:0]     r_b [3];
    logic signed [EW-1:0]   r_e [3];
    logic signed [EW-1:0]   r_erow [3];
    logic signed [EW-1:0]   r_den;
    logic [SB-1:0]          r_xmin, r_xmax, r_ymax;
    logic [SB-1:0]          r_sx, r_sy;
    logic [trsr_pkg::COLOR_W-1:0] r_color;

    // Result register
    logic                   r_out_valid;
    logic [trsr_pkg::PIX_W-1:0]   r_px, r_py;
    logic                   r_cov;
    logic [trsr_pkg::COLOR_W-1:0] r_col;
    logic                   r_last;

    logic                   out_free;
    logic                   exec;
    logic                   exec_load;
    logic                   exec_step;
    logic [SB:0]            x_inc, y_inc;
    logic                   row_more;
    logic                   col_more;
    logic                   fin;
    logic                   cov;
    logic [2:0]             edge_ok;
    logic                   n_active;

    assign out_free  = !r_out_valid || i_out_ready;
    assign o_take    = i_ctl.load || out_free;
    assign exec      = i_ctl.valid && o_take;
    assign exec_load = exec && i_ctl.load;
    assign exec_step = exec && !i_ctl.load;

    // Scan position bookkeeping
    assign x_inc    = {1'b0, r_sx} + (SB+1)'(1);
    assign y_inc    = {1'b0, r_sy} + (SB+1)'(1);
    assign row_more = x_inc < {1'b0, r_xmax};
    assign col_more = y_inc < {1'b0, r_ymax};
    assign fin      = !row_more && !col_more;
    assign n_active = (i_xmin < i_xmax) && (i_ymin < i_ymax);

    // Coverage: each edge value zero or of the area's sign, area nonzero
    for (genvar j = 0; j < 3; j++) begin : g_cov
        assign edge_ok[j] = (r_e[j] == '0) || (r_e[j][EW-1] == r_den[EW-1]);
    end
    assign cov = (r_den != '0) && (&edge_ok);

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (exec_load) begin
                r_active <= n_active;
            end else if (exec_step && r_active && fin) begin
                r_active <= 1'b0;
            end
            if (exec_step) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Triangle set-up on load, incremental walk on step
    always_ff @(posedge i_clk) begin
        if (exec_load) begin
            r_a    <= i_a;
            r_b    <= i_b;
            for (int j = 0; j < 3; j++) begin
                r_e[j]    <= EW'(i_pex[j]) + EW'(i_pey[j]);
                r_erow[j] <= EW'(i_pex[j]) + EW'(i_pey[j]);
            end
            r_den   <= EW'(i_pd0) + EW'(i_pd1);
            r_xmin  <= i_xmin;
            r_xmax  <= i_xmax;
            r_ymax  <= i_ymax;
            r_sx    <= i_xmin;
            r_sy    <= i_ymin;
            r_color <= i_color;
        end else if (exec_step && r_active) begin
            if (row_more) begin
                r_sx <= x_inc[SB-1:0];
                for (int j = 0; j < 3; j++) begin
                    r_e[j] <= r_e[j] + EW'(r_a[j]);
                end
            end else begin
                r_sx <= r_xmin;
                r_sy <= y_inc[SB-1:0];
                for (int j = 0; j < 3; j++) begin
                    r_erow[j] <= r_erow[j] + EW'(r_b[j]);
                    r_e[j]    <= r_erow[j] + EW'(r_b[j]);
                end
            end
        end
    end

    // Result beat
    always_ff @(posedge i_clk) begin
        if (exec_step) begin
            if (r_active) begin
                r_px   <= trsr_pkg::PIX_W'(r_sx);
                r_py   <= trsr_pkg::PIX_W'(r_sy);
                r_cov  <= cov;
                r_col  <= cov ? r_color : '0;
                r_last <= fin;
            end else begin
                r_px   <= '0;
                r_py   <= '0;
                r_cov  <= 1'b0;
                r_col  <= '0;
                r_last <= 1'b1;
            end
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_pixel_x     = r_px;
    assign o_pixel_y     = r_py;
    assign o_covered     = r_cov;
    assign o_pixel_color = r_col;
    assign o_last        = r_last;

    // Scan position stays inside the box while a scan runs
    a_scan_in_box: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_active |-> (r_sx >= r_xmin) && (r_sx < r_xmax) && (r_sy < r_ymax))
        else $error("scan position left the bounding box");

    // A load starts the pixel and row edge values together
    a_load_row_sync: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        exec_load |=> (r_e[0] == r_erow[0]) && (r_e[2] == r_erow[2]))
        else $error("edge values out of step after load");

    // A step with no scan running gives a lone uncovered last beat
    a_idle_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        exec_step && !r_active |=> r_out_valid && r_last && !r_cov)
        else $error("idle step result malformed");

    // Uncovered pixels carry no colour
    a_uncovered_blank: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !r_cov |-> (r_col == '0))
        else $error("colour on uncovered pixel");

endmodule

`default_nettype wire

// ----- test/trsr_pixel_checker.sv -----
// Pixel beat checker for the triangle scan rasteriser: predicts every result beat
// from the accepted input beats and register writes, and compares them in order.
// Depends on trsr_pkg for field widths, opcodes and register indexes.
`timescale 1ns / 1ps

module trsr_pixel_checker (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    // Register writes
    input  wire logic                               i_cfg_we,
    input  wire logic [trsr_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  wire logic [trsr_pkg::CFG_W-1:0]         i_cfg_data,
    // Input channel
    input  wire logic                               i_in_valid,
    input  wire logic                               i_in_ready,
    input  wire logic                               i_op,
    input  wire logic signed [15:0]                 i_ax,
    input  wire logic signed [15:0]                 i_ay,
    input  wire logic signed [15:0]                 i_bx,
    input  wire logic signed [15:0]                 i_by_coord,
    input  wire logic signed [15:0]                 i_cx_coord,
    input  wire logic signed [15:0]                 i_cy_coord,
    input  wire logic [trsr_pkg::COLOR_W-1:0]       i_fill_color,
    // Result channel
    input  wire logic                               i_out_valid,
    input  wire logic                               i_out_ready,
    input  wire logic [trsr_pkg::PIX_W-1:0]         i_pixel_x,
    input  wire logic [trsr_pkg::PIX_W-1:0]         i_pixel_y,
    input  wire logic                               i_covered,
    input  wire logic [trsr_pkg::COLOR_W-1:0]       i_pixel_color,
    input  wire logic                               i_last,
    // Status for the testbench top
    output int                                      o_mismatches,
    output int                                      o_pixels_owed
);

    import trsr_pkg::*;

    typedef struct packed {
        logic [PIX_W-1:0]   x;
        logic [PIX_W-1:0]   y;
        logic               cov;
        logic [COLOR_W-1:0] colour;
        logic               last;
    } t_pixel_beat;

    // Shadow state of the rasteriser
    logic [CFG_W-1:0]   width_reg;
    logic [CFG_W-1:0]   height_reg;
    longint             vtx [6];        // ax, ay, bx, by, cx, cy
    logic [COLOR_W-1:0] tri_colour;
    longint             denom [3];
    longint             box_x0, box_x1, box_y0, box_y1;
    longint             scan_x, scan_y;
    bit                 scan_on;

    t_pixel_beat        pixel_queue [$];
    int                 fails = 0;

    // Edge function of edge j (the edge opposite vertex j) at (px, py)
    function automatic longint edge_fn(int j, longint px, longint py);
        int     u, w;
        longint xu, yu, xw, yw;
        u  = (j + 1) % 3;
        w  = (j + 2) % 3;
        xu = vtx[2*u];
        yu = vtx[2*u+1];
        xw = vtx[2*w];
        yw = vtx[2*w+1];
        return (yu - yw) * px + (xw - xu) * py + xu * yw - xw * yu;
    endfunction

    // Covered when each numerator is zero or shares the sign of a nonzero denominator
    function automatic bit pixel_inside(longint px, longint py);
        longint n;
        for (int j = 0; j < 3; j++) begin
            n = edge_fn(j, px, py);
            if (denom[j] == 0) return 1'b0;
            if (n == 0) continue;
            if ((n < 0) != (denom[j] < 0)) return 1'b0;
        end
        return 1'b1;
    endfunction

    function automatic longint clip(longint v, longint hi);
        if (v < 0) return 0;
        if (v > hi) return hi;
        return v;
    endfunction

    // Load beat: latch the triangle, its denominators and the clamped box
    function automatic void latch_triangle();
        longint wl, hl, xlo, xhi, ylo, yhi;
        wl = (width_reg > MAX_SCREEN_DEF) ? MAX_SCREEN_DEF : width_reg;
        hl = (height_reg > MAX_SCREEN_DEF) ? MAX_SCREEN_DEF : height_reg;
        vtx[0] = longint'(i_ax);
        vtx[1] = longint'(i_ay);
        vtx[2] = longint'(i_bx);
        vtx[3] = longint'(i_by_coord);
        vtx[4] = longint'(i_cx_coord);
        vtx[5] = longint'(i_cy_coord);
        tri_colour = i_fill_color;
        for (int j = 0; j < 3; j++)
            denom[j] = edge_fn(j, vtx[2*j], vtx[2*j+1]);
        xlo = vtx[0];
        xhi = vtx[0];
        ylo = vtx[1];
        yhi = vtx[1];
        for (int j = 1; j < 3; j++) begin
            if (vtx[2*j] < xlo) xlo = vtx[2*j];
            if (vtx[2*j] > xhi) xhi = vtx[2*j];
            if (vtx[2*j+1] < ylo) ylo = vtx[2*j+1];
            if (vtx[2*j+1] > yhi) yhi = vtx[2*j+1];
        end
        box_x0  = clip(xlo, wl);
        box_x1  = clip(xhi, wl);
        box_y0  = clip(ylo, hl);
        box_y1  = clip(yhi, hl);
        scan_x  = box_x0;
        scan_y  = box_y0;
        scan_on = (box_x0 < box_x1) && (box_y0 < box_y1);
    endfunction

    // Step beat: visit the next box pixel in row order, or report an idle step
    function automatic t_pixel_beat next_pixel();
        t_pixel_beat b;
        bit          cov;
        if (!scan_on) begin
            b = '{x: '0, y: '0, cov: 1'b0, colour: '0, last: 1'b1};
            return b;
        end
        cov      = pixel_inside(scan_x, scan_y);
        b.x      = PIX_W'(scan_x);
        b.y      = PIX_W'(scan_y);
        b.cov    = cov;
        b.colour = cov ? tri_colour : '0;
        b.last   = (scan_x + 1 >= box_x1) && (scan_y + 1 >= box_y1);
        if (scan_x + 1 < box_x1) begin
            scan_x++;
        end else begin
            scan_x = box_x0;
            scan_y++;
            if (scan_y >= box_y1) scan_on = 1'b0;
        end
        return b;
    endfunction

    // Track writes and beats on both channels
    always @(posedge i_clk) begin : watch
        t_pixel_beat want;
        if (!i_rst_n) begin
            width_reg  = WIDTH_RST;
            height_reg = HEIGHT_RST;
            foreach (vtx[k]) vtx[k] = 0;
            foreach (denom[k]) denom[k] = 0;
            tri_colour = '0;
            box_x0     = 0;
            box_x1     = 0;
            box_y0     = 0;
            box_y1     = 0;
            scan_x     = 0;
            scan_y     = 0;
            scan_on    = 1'b0;
            pixel_queue.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_WIDTH:  width_reg  = i_cfg_data;
                    REG_HEIGHT: height_reg = i_cfg_data;
                    default: ;
                endcase
            end

            // Result beat against the oldest prediction
            if (i_out_valid && i_out_ready) begin
                if (pixel_queue.size() == 0) begin
                    fails++;
                    $display("%0t: unexpected pixel beat x=%0d y=%0d covered=%0b colour=%h last=%0b",
                             $time, i_pixel_x, i_pixel_y, i_covered, i_pixel_color, i_last);
                end else begin
                    want = pixel_queue.pop_front();
                    if (i_pixel_x !== want.x) begin
                        fails++;
                        $display("%0t: pixel_x expected %0d got %0d", $time, want.x, i_pixel_x);
                    end
                    if (i_pixel_y !== want.y) begin
                        fails++;
                        $display("%0t: pixel_y expected %0d got %0d", $time, want.y, i_pixel_y);
                    end
                    if (i_covered !== want.cov) begin
                        fails++;
                        $display("%0t: covered expected %0b got %0b at (%0d,%0d)",
                                 $time, want.cov, i_covered, want.x, want.y);
                    end
                    if (i_pixel_color !== want.colour) begin
                        fails++;
                        $display("%0t: pixel_color expected %h got %h at (%0d,%0d)",
                                 $time, want.colour, i_pixel_color, want.x, want.y);
                    end
                    if (i_last !== want.last) begin
                        fails++;
                        $display("%0t: last expected %0b got %0b at (%0d,%0d)",
                                 $time, want.last, i_last, want.x, want.y);
                    end
                end
            end

            // Input beat: loads update the shadow state, steps owe one pixel beat
            if (i_in_valid && i_in_ready) begin
                if (i_op == OP_LOAD)
                    latch_triangle();
                else
                    pixel_queue.push_back(next_pixel());
            end
        end
        o_pixels_owed <= pixel_queue.size();
        o_mismatches  <= fails;
    end

endmodule

// ----- test/tb_triangle_scan_rasterizer_unit.sv -----
// Testbench top for triangle_scan_rasterizer_unit: drives load and step beats,
// register writes and a stalling receiver, and reports the verdict.
// Depends on trsr_pkg, the rasteriser RTL and trsr_pixel_checker.
`timescale 1ns / 1ps

module tb_triangle_scan_rasterizer_unit;

    import trsr_pkg::*;

    localparam int LIMIT       = 200000;
    localparam int HOLD_CYCLES = 300;

    logic                    i_clk;
    logic                    i_rst_n;
    logic                    i_cfg_we;
    logic [CFG_IDX_W-1:0]    i_cfg_index;
    logic [CFG_W-1:0]        i_cfg_data;
    logic                    i_in_valid;
    logic                    o_in_ready;
    logic                    i_op;
    logic signed [15:0]      i_ax, i_ay, i_bx, i_by_coord, i_cx_coord, i_cy_coord;
    logic [COLOR_W-1:0]      i_fill_color;
    logic                    o_out_valid;
    logic                    i_out_ready;
    logic [PIX_W-1:0]        o_pixel_x;
    logic [PIX_W-1:0]        o_pixel_y;
    logic                    o_covered;
    logic [COLOR_W-1:0]      o_pixel_color;
    logic                    o_last;

    int mismatches;
    int pixels_owed;
    int cycles;
    int beats_sent;
    int cur_w;          // screen limits as the block will clamp them
    int cur_h;
    bit calm;           // no idling on either side while set
    int hold_reqs;      // each increment asks the receiver for one long hold-off

    triangle_scan_rasterizer_unit u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_op          (i_op),
        .i_ax          (i_ax),
        .i_ay          (i_ay),
        .i_bx          (i_bx),
        .i_by_coord    (i_by_coord),
        .i_cx_coord    (i_cx_coord),
        .i_cy_coord    (i_cy_coord),
        .i_fill_color  (i_fill_color),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_pixel_x     (o_pixel_x),
        .o_pixel_y     (o_pixel_y),
        .o_covered     (o_covered),
        .o_pixel_color (o_pixel_color),
        .o_last        (o_last)
    );

    trsr_pixel_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_in_valid    (i_in_valid),
        .i_in_ready    (o_in_ready),
        .i_op          (i_op),
        .i_ax          (i_ax),
        .i_ay          (i_ay),
        .i_bx          (i_bx),
        .i_by_coord    (i_by_coord),
        .i_cx_coord    (i_cx_coord),
        .i_cy_coord    (i_cy_coord),
        .i_fill_color  (i_fill_color),
        .i_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .i_pixel_x     (o_pixel_x),
        .i_pixel_y     (o_pixel_y),
        .i_covered     (o_covered),
        .i_pixel_color (o_pixel_color),
        .i_last        (o_last),
        .o_mismatches  (mismatches),
        .o_pixels_owed (pixels_owed)
    );

    // 50 MHz clock
    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Receiver: random back-pressure, a calm stretch, and one long hold-off on request
    initial begin : receiver
        int hold_done;
        hold_done = 0;
        i_out_ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_reqs != hold_done) begin
                hold_done++;
                i_out_ready <= 1'b0;
                for (int n = 0; n < HOLD_CYCLES; n++) @(posedge i_clk);
            end
            i_out_ready <= calm || ($urandom_range(0, 99) >= 37);
        end
    end

    // Watchdog
    initial begin
        cycles = 0;
        while (cycles < LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("triangle_scan_rasterizer_unit regression: fail");
        $finish;
    end

    // One input beat, with a random gap before it; returns at the accepting edge
    task automatic send_beat(t_op opv, logic signed [15:0] xa, logic signed [15:0] ya,
                             logic signed [15:0] xb, logic signed [15:0] yb,
                             logic signed [15:0] xc, logic signed [15:0] yc,
                             logic [COLOR_W-1:0] colour);
        while (!calm && $urandom_range(0, 99) < 37) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_op         <= opv;
        i_ax         <= xa;
        i_ay         <= ya;
        i_bx         <= xb;
        i_by_coord   <= yb;
        i_cx_coord   <= xc;
        i_cy_coord   <= yc;
        i_fill_color <= colour;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        beats_sent++;
    endtask

    // Step beats carry junk vertex fields, which the block ignores
    task automatic step_beats(int n);
        repeat (n)
            send_beat(OP_STEP, 16'($urandom), 16'($urandom), 16'($urandom),
                      16'($urandom), 16'($urandom), 16'($urandom), $urandom);
    endtask

    function automatic int clip(int v, int hi);
        return (v < 0) ? 0 : ((v > hi) ? hi : v);
    endfunction

    // Load a triangle, then step through its box: whole (plus extra idle steps)
    // or cut short at random, and never more than most steps
    task automatic scan_triangle(int xa, int ya, int xb, int yb, int xc, int yc,
                                 logic [COLOR_W-1:0] colour, int extra, bit cut, int most);
        int x0, x1, y0, y1, area, steps;
        x0 = xa;
        x1 = xa;
        y0 = ya;
        y1 = ya;
        if (xb < x0) x0 = xb;
        if (xc < x0) x0 = xc;
        if (xb > x1) x1 = xb;
        if (xc > x1) x1 = xc;
        if (yb < y0) y0 = yb;
        if (yc < y0) y0 = yc;
        if (yb > y1) y1 = yb;
        if (yc > y1) y1 = yc;
        x0    = clip(x0, cur_w);
        x1    = clip(x1, cur_w);
        y0    = clip(y0, cur_h);
        y1    = clip(y1, cur_h);
        area  = (x0 < x1 && y0 < y1) ? (x1 - x0) * (y1 - y0) : 0;
        steps = cut ? $urandom_range(1, (area > 1) ? area : 1) : area + extra;
        if (steps > most) steps = most;
        send_beat(OP_LOAD, 16'(xa), 16'(ya), 16'(xb), 16'(yb), 16'(xc), 16'(yc), colour);
        step_beats(steps);
    endtask

    // Drop valid and wait until every owed pixel beat is out and the pipe has drained
    task automatic settle();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pixels_owed != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic set_screen(int w, int h);
        settle();
        i_cfg_we    <= 1'b1;
        i_cfg_index <= REG_WIDTH;
        i_cfg_data  <= CFG_W'(w);
        @(posedge i_clk);
        i_cfg_index <= REG_HEIGHT;
        i_cfg_data  <= CFG_W'(h);
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        cur_w = (w > MAX_SCREEN_DEF) ? MAX_SCREEN_DEF : w;
        cur_h = (h > MAX_SCREEN_DEF) ? MAX_SCREEN_DEF : h;
    endtask

    function automatic int pick_anchor(int lim);
        case ($urandom_range(0, 3))
            0:       return -3;
            1:       return $urandom_range(0, 20);
            2:       return lim - 4;
            default: return $urandom_range(0, lim);
        endcase
    endfunction

    function automatic int any_coord();
        return int'($urandom_range(0, 65535)) - 32768;
    endfunction

    // Mostly small triangles scanned to the end; some degenerate, some full-range, lone steps
    task automatic run_random(int budget);
        int target, kind, ox, oy, span, dx, dy;
        target = beats_sent + budget;
        while (beats_sent < target) begin
            kind = $urandom_range(0, 99);
            ox   = pick_anchor(cur_w);
            oy   = pick_anchor(cur_h);
            span = $urandom_range(1, 5);
            if (kind < 80) begin
                scan_triangle(ox + $urandom_range(0, span), oy + $urandom_range(0, span),
                              ox + $urandom_range(0, span), oy + $urandom_range(0, span),
                              ox + $urandom_range(0, span), oy + $urandom_range(0, span),
                              $urandom, $urandom_range(0, 1), $urandom_range(0, 4) == 0, 40);
            end else if (kind < 85) begin
                // collinear vertices: zero area
                dx = $urandom_range(0, 3);
                dy = $urandom_range(0, 3);
                scan_triangle(ox, oy, ox + dx, oy + dy, ox + 2*dx, oy + 2*dy,
                              $urandom, 0, 1'b0, 3);
            end else if (kind < 93) begin
                scan_triangle(any_coord(), any_coord(), any_coord(), any_coord(),
                              any_coord(), any_coord(), $urandom, 0, 1'b0,
                              $urandom_range(0, 3));
            end else begin
                step_beats($urandom_range(1, 3));
            end
        end
    endtask

    // Stimulus and verdict
    initial begin
        i_rst_n      <= 1'b0;
        i_cfg_we     <= 1'b0;
        i_cfg_index  <= REG_WIDTH;
        i_cfg_data   <= '0;
        i_in_valid   <= 1'b0;
        i_op         <= OP_LOAD;
        i_ax         <= '0;
        i_ay         <= '0;
        i_bx         <= '0;
        i_by_coord   <= '0;
        i_cx_coord   <= '0;
        i_cy_coord   <= '0;
        i_fill_color <= '0;
        calm         <= 1'b0;
        hold_reqs    <= 0;
        beats_sent    = 0;
        cur_w         = 640;
        cur_h         = 480;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part at the reset screen size of 640 by 480
        step_beats(1);                                          // idle step after reset
        scan_triangle(0, 0, 3, 0, 0, 2, 32'hFFFF_FFFF, 1, 1'b0, 40);   // whole box, then idle
        scan_triangle(1, 1, 3, 3, 5, 5, 32'h0000_0000, 0, 1'b0, 2);    // zero area
        scan_triangle(-32768, -32768, 32767, -32768, -32768, 32767,
                      32'hA5C3_5A3C, 0, 1'b0, 2);               // extremes, replaced mid-scan
        scan_triangle(-9, 3, -2, 4, -5, 1, 32'h1234_5678, 1, 1'b0, 40); // box clamps empty
        scan_triangle(630, 470, 700, 470, 630, 500, 32'h00FF_00FF, 0, 1'b0, 2);
        scan_triangle(0, 0, 0, 2, 3, 0, 32'h8000_0001, 0, 1'b0, 3);    // opposite winding

        // Random phases across screen settings
        set_screen(1, 1);
        run_random(40);

        set_screen(8191, 4096);                                 // oversized width
        calm <= 1'b1;
        run_random(90);
        calm <= 1'b0;

        set_screen(0, 5);                                       // zero width: every box empty
        run_random(40);

        set_screen(13, 9);
        hold_reqs <= hold_reqs + 1;
        run_random(90);

        set_screen($urandom_range(1, 40), $urandom_range(1, 40));
        run_random(100);

        set_screen(640, 480);
        run_random(90);

        settle();
        if (mismatches == 0 && pixels_owed == 0)
            $display("triangle_scan_rasterizer_unit regression: pass");
        else
            $display("triangle_scan_rasterizer_unit regression: fail");
        $finish;
    end

endmodule

// ----- files.f -----
sv/trsr_pkg.sv
sv/trsr_setup.sv
sv/trsr_mul.sv
sv/trsr_scan.sv
sv/triangle_scan_rasterizer_unit.sv
test/trsr_pixel_checker.sv
test/tb_triangle_scan_rasterizer_unit.sv
